FILE: hdl/dhp_pkg.sv
// ----------------------------------------------------------------------------
// dhp_pkg
// Shared types, status codes and default limits for the DER header parser.
// ----------------------------------------------------------------------------
package dhp_pkg;

    // default limits, handed down through the top level parameters
    localparam int DHP_MAX_LENGTH_OCTETS = 4;
    localparam int DHP_MAX_TAG_OCTETS    = 4;

    // field widths fixed by the format
    localparam int TAG_W = 28;
    localparam int LEN_W = 32;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_TAG = 2'd1;
    localparam logic [1:0] ST_LEN_LONG = 2'd2;
    localparam logic [1:0] ST_TAG_LONG = 2'd3;

    // one decoded header result
    typedef struct packed {
        logic [1:0]       tag_class;
        logic             constructed;
        logic [TAG_W-1:0] tag_number;
        logic [LEN_W-1:0] content_length;
        logic             indefinite;
        logic [1:0]       status;
    } result_t;

endpackage

FILE: hdl/dhp_if.sv
// ----------------------------------------------------------------------------
// dhp_in_if / dhp_out_if
// Valid/ready channels for header octets in and decoded headers out.
// ----------------------------------------------------------------------------
interface dhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface dhp_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                tag_class;
    logic                      constructed;
    logic [dhp_pkg::TAG_W-1:0] tag_number;
    logic [dhp_pkg::LEN_W-1:0] content_length;
    logic                      indefinite;
    logic [1:0]                status;

    modport source (output valid, output tag_class, output constructed,
                    output tag_number, output content_length,
                    output indefinite, output status, input ready);
    modport sink   (input valid, input tag_class, input constructed,
                    input tag_number, input content_length,
                    input indefinite, input status, output ready);
endinterface

FILE: hdl/dhp_decode.sv
// ----------------------------------------------------------------------------
// dhp_decode
// Header state registers and the one-octet decode step.
// ----------------------------------------------------------------------------
module dhp_decode #(
    parameter int MAX_LENGTH_OCTETS = dhp_pkg::DHP_MAX_LENGTH_OCTETS,
    parameter int MAX_TAG_OCTETS    = dhp_pkg::DHP_MAX_TAG_OCTETS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [7:0]       data_byte,
    input  logic             restart,
    output logic             res_valid,
    output dhp_pkg::result_t res
);

    localparam int TCW = $clog2(MAX_TAG_OCTETS + 1);
    localparam int LCW = $clog2(MAX_LENGTH_OCTETS + 1);
    localparam int TW  = dhp_pkg::TAG_W;
    localparam int LW  = dhp_pkg::LEN_W;

    localparam logic [1:0] PH_IDENT    = 2'd0;
    localparam logic [1:0] PH_HIGHTAG  = 2'd1;
    localparam logic [1:0] PH_LENFIRST = 2'd2;
    localparam logic [1:0] PH_LENLONG  = 2'd3;

    logic [1:0]     phase_reg, phase_next;
    logic [1:0]     class_reg, class_next;
    logic           cons_reg, cons_next;
    logic [TW-1:0]  tag_reg, tag_next;
    logic [TCW-1:0] tcnt_reg, tcnt_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [LCW-1:0] left_reg, left_next;

    logic [1:0]     cur_phase;
    logic [TW-1:0]  tag_shift;
    logic [TCW-1:0] tcnt_inc;
    logic [LW-1:0]  len_shift;
    logic [LCW-1:0] left_dec;
    logic [6:0]     len_count;

    // step arithmetic: shift and merge one octet
    assign cur_phase = restart ? PH_IDENT : phase_reg;
    assign tag_shift = {tag_reg[TW-8:0], data_byte[6:0]};
    assign tcnt_inc  = tcnt_reg + TCW'(1);
    assign len_shift = {len_reg[LW-9:0], data_byte};
    assign left_dec  = (left_reg != '0) ? left_reg - LCW'(1) : left_reg;
    assign len_count = data_byte[6:0];

    // next state and result
    always_comb
    begin
        phase_next = phase_reg;
        class_next = class_reg;
        cons_next  = cons_reg;
        tag_next   = tag_reg;
        tcnt_next  = tcnt_reg;
        len_next   = len_reg;
        left_next  = left_reg;

        res_valid          = 1'b0;
        res.tag_class      = class_reg;
        res.constructed    = cons_reg;
        res.tag_number     = tag_reg;
        res.content_length = '0;
        res.indefinite     = 1'b0;
        res.status         = dhp_pkg::ST_OK;

        if (in_fire)
        begin
            case (cur_phase)
                PH_IDENT:
                begin
                    class_next = data_byte[7:6];
                    cons_next  = data_byte[5];
                    tcnt_next  = '0;
                    len_next   = '0;
                    left_next  = '0;
                    if (data_byte[4:0] == 5'h1f)
                    begin
                        tag_next   = '0;
                        phase_next = PH_HIGHTAG;
                    end
                    else
                    begin
                        tag_next   = TW'(data_byte[4:0]);
                        phase_next = PH_LENFIRST;
                    end
                end
                PH_HIGHTAG:
                begin
                    if (tcnt_reg == '0 && data_byte[6:0] == 7'd0)
                    begin
                        res_valid  = 1'b1;
                        res.status = dhp_pkg::ST_ZERO_TAG;
                        phase_next = PH_IDENT;
                    end
                    else
                    begin
                        tag_next  = tag_shift;
                        tcnt_next = tcnt_inc;
                        if (data_byte[7])
                        begin
                            // continuation octet at the limit ends the header
                            if (tcnt_inc >= TCW'(MAX_TAG_OCTETS))
                            begin
                                res_valid      = 1'b1;
                                res.tag_number = tag_shift;
                                res.status     = dhp_pkg::ST_TAG_LONG;
                                phase_next     = PH_IDENT;
                            end
                        end
                        else
                        begin
                            phase_next = PH_LENFIRST;
                        end
                    end
                end
                PH_LENFIRST:
                begin
                    if (data_byte == 8'h80)
                    begin
                        res_valid      = 1'b1;
                        res.indefinite = 1'b1;
                        phase_next     = PH_IDENT;
                    end
                    else if (!data_byte[7])
                    begin
                        res_valid          = 1'b1;
                        res.content_length = LW'(data_byte);
                        phase_next         = PH_IDENT;
                    end
                    else if (len_count > 7'(MAX_LENGTH_OCTETS))
                    begin
                        res_valid  = 1'b1;
                        res.status = dhp_pkg::ST_LEN_LONG;
                        phase_next = PH_IDENT;
                    end
                    else
                    begin
                        len_next   = '0;
                        left_next  = LCW'(len_count);
                        phase_next = PH_LENLONG;
                    end
                end
                PH_LENLONG:
                begin
                    len_next  = len_shift;
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        res_valid          = 1'b1;
                        res.content_length = len_shift;
                        phase_next         = PH_IDENT;
                    end
                end
                default:
                begin
                    phase_next = PH_IDENT;
                end
            endcase
        end
    end

    // header state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDENT;
            class_reg <= '0;
            cons_reg  <= 1'b0;
            tag_reg   <= '0;
            tcnt_reg  <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            class_reg <= class_next;
            cons_reg  <= cons_next;
            tag_reg   <= tag_next;
            tcnt_reg  <= tcnt_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
        end
    end

endmodule

FILE: hdl/dhp_out_reg.sv
// ----------------------------------------------------------------------------
// dhp_out_reg
// Result register that decouples the decoder from a stalling receiver.
// ----------------------------------------------------------------------------
module dhp_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  dhp_pkg::result_t res,
    input  logic             out_ready,
    output logic             out_valid,
    output dhp_pkg::result_t out_res,
    output logic             in_ready
);

    logic             valid_reg, valid_next;
    dhp_pkg::result_t res_reg;

    // a new request is taken while the slot is empty or draining
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // slot occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

FILE: hdl/der_header_parser_unit.sv
// ----------------------------------------------------------------------------
// der_header_parser_unit
// ASN.1 DER identifier and length header decoder, one octet per cycle while hdr_out drains.
// ----------------------------------------------------------------------------
// Usage:
//   hdr_in carries one header octet per request (data_byte) and a restart
//   flag that drops any partial header and takes the octet as an identifier.
//   hdr_out carries one decoded header per request: class, constructed flag,
//   tag number, content length, indefinite flag and status.
//   Throughput: one octet per cycle, sustained, as long as hdr_out drains.
//   Results: the result of the octet that completes (or fails) a header is
//   presented on hdr_out in the cycle after that octet is accepted, from the
//   result register, which the decode step loads directly.
//   Octets that do not finish a header only update the header state.
//   Receiver stall: the result register holds its request; hdr_in.ready
//   drops only while a result waits and hdr_out.ready is low.
//   Reset: asynchronous, active low; the parser then expects an identifier
//   octet and the result register is empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module der_header_parser_unit #(
    parameter int MAX_LENGTH_OCTETS = dhp_pkg::DHP_MAX_LENGTH_OCTETS,
    parameter int MAX_TAG_OCTETS    = dhp_pkg::DHP_MAX_TAG_OCTETS
) (
    input  logic        clk,
    input  logic        rst_n,
    dhp_in_if.sink      hdr_in,
    dhp_out_if.source   hdr_out
);

    logic             in_ready;
    logic             in_fire;
    logic             res_valid;
    dhp_pkg::result_t res;
    dhp_pkg::result_t out_res;
    logic             out_valid;

    assign hdr_in.ready = in_ready;
    assign in_fire      = hdr_in.valid && in_ready;

    // decode step and header state
    dhp_decode #(
        .MAX_LENGTH_OCTETS (MAX_LENGTH_OCTETS),
        .MAX_TAG_OCTETS    (MAX_TAG_OCTETS)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .data_byte (hdr_in.data_byte),
        .restart   (hdr_in.restart),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register
    dhp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_ready (hdr_out.ready),
        .out_valid (out_valid),
        .out_res   (out_res),
        .in_ready  (in_ready)
    );

    // drive the result channel
    assign hdr_out.valid          = out_valid;
    assign hdr_out.tag_class      = out_res.tag_class;
    assign hdr_out.constructed    = out_res.constructed;
    assign hdr_out.tag_number     = out_res.tag_number;
    assign hdr_out.content_length = out_res.content_length;
    assign hdr_out.indefinite     = out_res.indefinite;
    assign hdr_out.status         = out_res.status;

`ifndef SYNTH
    // a waiting result blocks new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_out.valid && !hdr_out.ready) |-> !hdr_in.ready)
        else $error("request accepted while result stalled");

    // error results carry no length
    a_err_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_out.valid && hdr_out.status != dhp_pkg::ST_OK) |->
        (hdr_out.content_length == '0 && !hdr_out.indefinite))
        else $error("error result with length");

    // indefinite form reports zero length
    a_indef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_out.valid && hdr_out.indefinite) |->
        (hdr_out.content_length == '0 && hdr_out.status == dhp_pkg::ST_OK))
        else $error("indefinite result with length or error");

    // a result only appears after an accepted request
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hdr_out.valid) |-> $past(in_fire))
        else $error("result without request");
`endif

endmodule
